FILE: rtl/core/nec_ir_frame_decoder_unit_macros.svh
// Assertion macros shared by the NEC IR frame decoder RTL.
`ifndef NEC_IR_FRAME_DECODER_UNIT_MACROS_SVH
`define NEC_IR_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define NECIR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("necir assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define NECIR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("necir assertion failed");

`else

`define NECIR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NECIR_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/necir_pkg.sv
// Types and constants of the NEC IR frame decoder.
package necir_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned REG_COUNT  = 8;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_START_PERIOD  = 3'd0,
    REG_START_PULSE   = 3'd1,
    REG_REPEAT_PERIOD = 3'd2,
    REG_REPEAT_PULSE  = 3'd3,
    REG_ZERO_PERIOD   = 3'd4,
    REG_ZERO_PULSE    = 3'd5,
    REG_ONE_PERIOD    = 3'd6,
    REG_ONE_PULSE     = 3'd7
  } reg_index_t;

  localparam logic [15:0] RST_START_PERIOD  = 16'd13500;
  localparam logic [15:0] RST_START_PULSE   = 16'd9000;
  localparam logic [15:0] RST_REPEAT_PERIOD = 16'd11250;
  localparam logic [15:0] RST_REPEAT_PULSE  = 16'd9000;
  localparam logic [15:0] RST_ZERO_PERIOD   = 16'd1125;
  localparam logic [15:0] RST_ZERO_PULSE    = 16'd560;
  localparam logic [15:0] RST_ONE_PERIOD    = 16'd2250;
  localparam logic [15:0] RST_ONE_PULSE     = 16'd560;

  // Count value once the leader and all bit slots are in; the next pair closes.
  localparam logic [5:0] CLOSE_COUNT = 6'(FRAME_BITS + 1);

  typedef struct packed {
    logic        receiving;
    logic [15:0] code;
    logic        frame_ok;
    logic        frame_done;
    logic        accepted;
  } result_t;

endpackage

FILE: rtl/core/nec_ir_frame_decoder_unit.sv
// NEC IR frame decoder top level: pair classification, frame shift and checks.
//
// Input words on s_axis carry one measured (period, pulse) timer pair each.
// A pair matching the leader opens a frame; the next 32 pairs are classified
// as zero or one and shifted in LSB first; the pair after that closes the frame
// and reports the 16-bit code when every slot classified and both inverse byte
// checks pass. A leader or repeat pattern in the middle of a frame drops it.
// Every input word gives exactly one output word on m_axis.
// A word is held in the input register, then loaded into the result register and
// can be taken from there. Throughput: one word per cycle while m_tready stays
// high; the classification is a single pass of subtract/compare logic between
// the input register and the result register.
// If the receiver stalls, the result register holds, an empty input register
// takes one more word, and then s_tready drops until m_tready returns.
// Reset (rst, synchronous) empties both registers, ends any frame in progress
// and loads the register defaults. Timing registers are written through the
// APB port and should only be changed while no word is in flight.
`include "nec_ir_frame_decoder_unit_macros.svh"

module nec_ir_frame_decoder_unit #(
  parameter int unsigned TIME_BITS        = 16,
  parameter int unsigned START_PERIOD_TOL = 1000,
  parameter int unsigned START_PULSE_TOL  = 1000,
  parameter int unsigned ZERO_PERIOD_TOL  = 200,
  parameter int unsigned ONE_PERIOD_TOL   = 300,
  parameter int unsigned BIT_PULSE_TOL    = 200
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] period_time, [31:16] pulse_time
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code
  output logic        m_tlast,   // frame_done
  output logic [2:0]  m_tuser    // [0] accepted, [1] frame_ok, [2] receiving
);

  localparam int unsigned MASK_BITS = (TIME_BITS < 16) ? TIME_BITS : 16;
  localparam logic [15:0] TIME_MASK = 16'((17'd1 << MASK_BITS) - 17'd1);
  localparam logic [15:0] START_PER_TOL = 16'(START_PERIOD_TOL);
  localparam logic [15:0] START_PUL_TOL = 16'(START_PULSE_TOL);
  localparam logic [15:0] ZERO_PER_TOL  = 16'(ZERO_PERIOD_TOL);
  localparam logic [15:0] ONE_PER_TOL   = 16'(ONE_PERIOD_TOL);
  localparam logic [15:0] BIT_PUL_TOL   = 16'(BIT_PULSE_TOL);

  function automatic logic near(input logic [15:0] t, input logic [15:0] nom,
                                input logic [15:0] tol);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] d;
    a = t & TIME_MASK;
    b = nom & TIME_MASK;
    d = (a >= b) ? (a - b) : (b - a);
    return d <= tol;
  endfunction

  // Configuration registers
  logic [15:0] start_period, start_pulse, repeat_period, repeat_pulse;
  logic [15:0] zero_period, zero_pulse, one_period, one_pulse;
  logic        cfg_we;
  necir_pkg::reg_index_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = necir_pkg::reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_period  <= necir_pkg::RST_START_PERIOD;
      start_pulse   <= necir_pkg::RST_START_PULSE;
      repeat_period <= necir_pkg::RST_REPEAT_PERIOD;
      repeat_pulse  <= necir_pkg::RST_REPEAT_PULSE;
      zero_period   <= necir_pkg::RST_ZERO_PERIOD;
      zero_pulse    <= necir_pkg::RST_ZERO_PULSE;
      one_period    <= necir_pkg::RST_ONE_PERIOD;
      one_pulse     <= necir_pkg::RST_ONE_PULSE;
    end else if (cfg_we) begin
      case (cfg_idx)
        necir_pkg::REG_START_PERIOD:  start_period  <= pwdata[15:0];
        necir_pkg::REG_START_PULSE:   start_pulse   <= pwdata[15:0];
        necir_pkg::REG_REPEAT_PERIOD: repeat_period <= pwdata[15:0];
        necir_pkg::REG_REPEAT_PULSE:  repeat_pulse  <= pwdata[15:0];
        necir_pkg::REG_ZERO_PERIOD:   zero_period   <= pwdata[15:0];
        necir_pkg::REG_ZERO_PULSE:    zero_pulse    <= pwdata[15:0];
        necir_pkg::REG_ONE_PERIOD:    one_period    <= pwdata[15:0];
        necir_pkg::REG_ONE_PULSE:     one_pulse     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      necir_pkg::REG_START_PERIOD:  prdata = {16'd0, start_period};
      necir_pkg::REG_START_PULSE:   prdata = {16'd0, start_pulse};
      necir_pkg::REG_REPEAT_PERIOD: prdata = {16'd0, repeat_period};
      necir_pkg::REG_REPEAT_PULSE:  prdata = {16'd0, repeat_pulse};
      necir_pkg::REG_ZERO_PERIOD:   prdata = {16'd0, zero_period};
      necir_pkg::REG_ZERO_PULSE:    prdata = {16'd0, zero_pulse};
      necir_pkg::REG_ONE_PERIOD:    prdata = {16'd0, one_period};
      necir_pkg::REG_ONE_PULSE:     prdata = {16'd0, one_pulse};
      default:                      prdata = 32'd0;
    endcase
  end

  // Input register
  logic        in_valid;
  logic [15:0] in_period;
  logic [15:0] in_pulse;
  logic        advance;
  logic        step;

  // The result register is free when empty or being drained this cycle.
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_period <= s_tdata[15:0];
      in_pulse  <= s_tdata[31:16];
    end
  end

  // Frame state
  logic [5:0]  pair_count, pair_count_next;
  logic [31:0] frame_shift, frame_shift_next;
  logic        bit_error, bit_error_next;
  logic        in_frame, in_frame_next;
  necir_pkg::result_t res_next, res;

  logic is_leader, is_repeat, is_zero, is_one;
  logic idle_slot, closing;
  logic bytes_ok;

  assign is_leader = near(in_period, start_period, START_PER_TOL) &&
                     near(in_pulse, start_pulse, START_PUL_TOL);
  assign is_repeat = near(in_period, repeat_period, START_PER_TOL) &&
                     near(in_pulse, repeat_pulse, START_PUL_TOL);
  assign is_zero   = near(in_period, zero_period, ZERO_PER_TOL) &&
                     near(in_pulse, zero_pulse, BIT_PUL_TOL);
  assign is_one    = near(in_period, one_period, ONE_PER_TOL) &&
                     near(in_pulse, one_pulse, BIT_PUL_TOL);

  assign idle_slot = !in_frame || (pair_count == 6'd0);
  assign closing   = !idle_slot && (pair_count >= necir_pkg::CLOSE_COUNT);
  assign bytes_ok  = (frame_shift[31:24] == ~frame_shift[23:16]) &&
                     (frame_shift[15:8] == ~frame_shift[7:0]);

  always_comb begin
    pair_count_next     = pair_count;
    frame_shift_next    = frame_shift;
    bit_error_next      = bit_error;
    in_frame_next       = in_frame;
    res_next.accepted   = 1'b0;
    res_next.frame_done = 1'b0;
    res_next.frame_ok   = 1'b0;
    res_next.code       = 16'd0;
    if (idle_slot) begin
      if (is_leader) begin
        frame_shift_next  = 32'd0;
        bit_error_next    = 1'b0;
        pair_count_next   = 6'd1;
        in_frame_next     = 1'b1;
        res_next.accepted = 1'b1;
      end else begin
        pair_count_next = 6'd0;
        in_frame_next   = 1'b0;
      end
    end else if (closing) begin
      res_next.accepted   = 1'b1;
      res_next.frame_done = 1'b1;
      if (!bit_error && bytes_ok) begin
        res_next.frame_ok = 1'b1;
        res_next.code     = {frame_shift[31:24], frame_shift[15:8]};
      end
      pair_count_next = 6'd0;
      in_frame_next   = 1'b0;
    end else if (is_leader || is_repeat) begin
      pair_count_next = 6'd0;
      in_frame_next   = 1'b0;
    end else begin
      // A slot matching both patterns counts as a zero; one matching
      // neither shifts in a zero and spoils the frame.
      frame_shift_next  = {(is_one && !is_zero), frame_shift[31:1]};
      bit_error_next    = bit_error || (!is_zero && !is_one);
      pair_count_next   = pair_count + 6'd1;
      res_next.accepted = 1'b1;
    end
    res_next.receiving = in_frame_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count  <= 6'd0;
      frame_shift <= 32'd0;
      bit_error   <= 1'b0;
      in_frame    <= 1'b0;
    end else if (step) begin
      pair_count  <= pair_count_next;
      frame_shift <= frame_shift_next;
      bit_error   <= bit_error_next;
      in_frame    <= in_frame_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign m_tdata = res.code;
  assign m_tlast = res.frame_done;
  assign m_tuser = {res.receiving, res.frame_ok, res.accepted};

  `NECIR_ASSERT_IMP(a_count_range, clk, rst, 1'b1, pair_count <= necir_pkg::CLOSE_COUNT)
  `NECIR_ASSERT_IMP(a_idle_count, clk, rst, !in_frame, pair_count == 6'd0)
  `NECIR_ASSERT_NXT(a_close_idle, clk, rst, step && closing, !in_frame && m_tvalid && m_tlast)
  `NECIR_ASSERT_IMP(a_ok_done, clk, rst, m_tvalid && m_tuser[1], m_tlast && m_tuser[0])
  `NECIR_ASSERT_IMP(a_code_ok, clk, rst, m_tvalid && !m_tuser[1], m_tdata == 16'd0)

endmodule
